@@ src/rtss_pkg.sv @@
// Shared types and constants of the record table sort and search block.
// Used by the front decoder, the command queue, the table engine and the top level.
// No dependencies.
`timescale 1ns / 1ps

package rtss_pkg;

    // Field widths of the input and result items.
    localparam int MODE_W  = 2;
    localparam int SCORE_W = 32;
    localparam int TAG_W   = 16;
    localparam int KIND_W  = 2;
    localparam int RANK_W  = 4;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    // Default number of table rows.
    localparam int TABLE_DEPTH_DEF = 16;

    // Entries of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Request modes on the input tuser.
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SORT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

    // Result kinds on the output tuser.
    localparam logic [KIND_W-1:0] KIND_ROW    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    // Decoded operation handed from the front to the engine.
    typedef enum logic [1:0] {
        OP_APPEND,
        OP_SORT,
        OP_FIND
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          tag;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [RANK_W-1:0]         rank;
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          tag;
        logic                      found;
        logic                      last;
    } out_item_t;

endpackage

@@ src/rtss_front.sv @@
// Front end: accepts input requests and turns them into engine commands.
// Depends on rtss_pkg; feeds rtss_cmd_queue.
`timescale 1ns / 1ps

module rtss_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rtss_pkg::IN_DATA_W-1:0] s_tdata,  // score[31:0], tag[47:32]
    input  logic [rtss_pkg::MODE_W-1:0]  s_tuser,    // mode[1:0]
    output logic                         push_valid,
    input  logic                         push_ready,
    output rtss_pkg::cmd_t               push_cmd
);
    import rtss_pkg::*;

    logic keep;

    // Unused modes are taken from the bus and dropped without a command.
    always_comb
    begin
        keep           = 1'b1;
        push_cmd.op    = OP_APPEND;
        push_cmd.score = $signed(s_tdata[SCORE_W-1:0]);
        push_cmd.tag   = s_tdata[SCORE_W+TAG_W-1:SCORE_W];
        unique case (s_tuser)
            MODE_APPEND: push_cmd.op = OP_APPEND;
            MODE_SORT:   push_cmd.op = OP_SORT;
            MODE_FIND:   push_cmd.op = OP_FIND;
            default:     keep        = 1'b0;
        endcase
    end

    // A request is taken whenever the queue has room.
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && keep;

endmodule

@@ src/rtss_cmd_queue.sv @@
// Short command queue between the front decoder and the table engine.
// Depends on rtss_pkg.
`timescale 1ns / 1ps

module rtss_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rtss_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rtss_pkg::cmd_t pop_cmd
);
    import rtss_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= PTR_W'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            if (do_pop)
                rd_ptr_reg <= PTR_W'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            if (do_push && !do_pop)
                fill_reg <= fill_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - CNT_W'(1);
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ src/rtss_engine.sv @@
// Table engine: holds the record memory and carries out append, sort and find.
// Depends on rtss_pkg; fed by rtss_cmd_queue, drives the result register.
`timescale 1ns / 1ps

module rtss_engine #(
    parameter int TABLE_DEPTH = rtss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  rtss_pkg::cmd_t      cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output rtss_pkg::out_item_t out_item
);
    import rtss_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REJECT,
        S_SORT_LOAD,
        S_SORT_CMP,
        S_SORT_WB,
        S_EMIT,
        S_FIND_CMP,
        S_FIND_OUT
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [IDX_W-1:0]          i_reg;
    logic [IDX_W-1:0]          j_reg;
    logic signed [SCORE_W-1:0] pivot_score_reg;
    logic [TAG_W-1:0]          pivot_tag_reg;
    logic [TAG_W-1:0]          find_tag_reg;
    logic                      hit_reg;
    out_item_t                 out_reg;
    logic                      out_valid_reg;

    // Record memory with one write and one registered read port.
    logic signed [SCORE_W-1:0] score_mem [TABLE_DEPTH];
    logic [TAG_W-1:0]          tag_mem [TABLE_DEPTH];
    logic signed [SCORE_W-1:0] rd_score_reg;
    logic [TAG_W-1:0]          rd_tag_reg;

    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic signed [SCORE_W-1:0] wr_score;
    logic [TAG_W-1:0]          wr_tag;

    logic                      table_full;
    logic                      table_empty;
    logic [IDX_W-1:0]          last_idx;
    logic                      j_last;
    logic                      i_last;
    logic                      swap;
    logic                      out_room;
    logic                      out_load;

    assign table_full  = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign table_empty = (count_reg == '0);
    assign last_idx    = IDX_W'(count_reg - CNT_W'(1));
    assign j_last      = (j_reg == last_idx);
    assign i_last      = (i_reg == last_idx);
    assign out_room    = !out_valid_reg || out_ready;
    assign cmd_ready   = (state_reg == S_IDLE);

    // A new result enters the output register in the states that emit one.
    assign out_load = out_room && ((state_reg == S_REJECT) || (state_reg == S_EMIT) ||
                                   (state_reg == S_FIND_OUT));

    // The held row never swaps with its own stale copy in memory.
    assign swap = (j_reg != i_reg) && (pivot_score_reg > rd_score_reg);

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Memory port control for each step of the sequencer.
    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_score = pivot_score_reg;
        wr_tag   = pivot_tag_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_APPEND:
                        begin
                            wr_en    = !table_full;
                            wr_addr  = count_reg[IDX_W-1:0];
                            wr_score = cmd.score;
                            wr_tag   = cmd.tag;
                        end
                        OP_SORT, OP_FIND:
                            rd_en = !table_empty;
                        default: ;
                    endcase
                end
            end
            S_SORT_LOAD:
                rd_en = 1'b1;
            S_SORT_CMP:
            begin
                wr_en   = swap;
                wr_addr = j_reg;
                rd_en   = !j_last;
                rd_addr = IDX_W'(j_reg + 1'b1);
            end
            S_SORT_WB:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                rd_en   = 1'b1;
                rd_addr = i_last ? '0 : IDX_W'(i_reg + 1'b1);
            end
            S_EMIT:
            begin
                rd_en   = out_room && !j_last;
                rd_addr = IDX_W'(j_reg + 1'b1);
            end
            S_FIND_CMP:
            begin
                rd_en   = (rd_tag_reg != find_tag_reg) && !j_last;
                rd_addr = IDX_W'(j_reg + 1'b1);
            end
            default: ;
        endcase
    end

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            score_mem[wr_addr] <= wr_score;
            tag_mem[wr_addr]   <= wr_tag;
        end
        if (rd_en)
        begin
            rd_score_reg <= score_mem[rd_addr];
            rd_tag_reg   <= tag_mem[rd_addr];
        end
    end

    // Sequencer, counters and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        i_reg        <= '0;
                        j_reg        <= '0;
                        find_tag_reg <= cmd.tag;
                        unique case (cmd.op)
                            OP_APPEND:
                            begin
                                if (table_full)
                                    state_reg <= S_REJECT;
                                else
                                    count_reg <= count_reg + CNT_W'(1);
                            end
                            OP_SORT:
                            begin
                                if (!table_empty)
                                    state_reg <= S_SORT_LOAD;
                            end
                            OP_FIND:
                            begin
                                hit_reg <= 1'b0;
                                if (table_empty)
                                    state_reg <= S_FIND_OUT;
                                else
                                    state_reg <= S_FIND_CMP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_REJECT:
                begin
                    if (out_room)
                    begin
                        out_reg   <= '{KIND_REJECT, '0, '0, '0, 1'b0, 1'b1};
                        state_reg <= S_IDLE;
                    end
                end
                // Row i moves into the pivot register; the inner pass starts at row 0.
                S_SORT_LOAD:
                begin
                    pivot_score_reg <= rd_score_reg;
                    pivot_tag_reg   <= rd_tag_reg;
                    j_reg           <= '0;
                    state_reg       <= S_SORT_CMP;
                end
                // Compare the pivot with row j; a larger pivot trades places with it.
                S_SORT_CMP:
                begin
                    if (swap)
                    begin
                        pivot_score_reg <= rd_score_reg;
                        pivot_tag_reg   <= rd_tag_reg;
                    end
                    if (j_last)
                        state_reg <= S_SORT_WB;
                    else
                        j_reg <= IDX_W'(j_reg + 1'b1);
                end
                // The pivot returns to row i; then the next pivot or the emit pass.
                S_SORT_WB:
                begin
                    if (i_last)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        i_reg     <= IDX_W'(i_reg + 1'b1);
                        state_reg <= S_SORT_LOAD;
                    end
                end
                S_EMIT:
                begin
                    if (out_room)
                    begin
                        out_reg <= '{KIND_ROW, RANK_W'(j_reg), rd_score_reg,
                                     rd_tag_reg, 1'b0, j_last};
                        if (j_last)
                            state_reg <= S_IDLE;
                        else
                            j_reg <= IDX_W'(j_reg + 1'b1);
                    end
                end
                // Scan rows in table order until the first tag match.
                S_FIND_CMP:
                begin
                    if (rd_tag_reg == find_tag_reg)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_FIND_OUT;
                    end
                    else if (j_last)
                        state_reg <= S_FIND_OUT;
                    else
                        j_reg <= IDX_W'(j_reg + 1'b1);
                end
                S_FIND_OUT:
                begin
                    if (out_room)
                    begin
                        out_reg <= '{KIND_FIND, '0,
                                     hit_reg ? rd_score_reg : '0,
                                     hit_reg ? rd_tag_reg : '0,
                                     hit_reg, 1'b1};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/record_table_sort_search.sv @@
// Top level of the record table sort and search block.
// Depends on rtss_pkg, rtss_front, rtss_cmd_queue and rtss_engine.
//
// Requests arrive on the s_ stream: tuser carries the mode (append, sort and
// emit, find by tag), tdata the score and tag. Results leave on the m_ stream:
// tuser carries the kind (table row, find answer, append rejected), tdata the
// rank, score, tag and found flag, and tlast marks the final result of a request.
// A front decoder drops unused modes and places commands in a four-entry queue,
// so requests are taken while the engine is still busy.
// Append writes the next free row; a full table gives one rejected result.
// Find scans rows in order, one per cycle.
// Sort holds one row in a pivot register and sweeps all rows against it through
// the single-read memory port, then emits the rows one per cycle while the
// receiver keeps tready high.
// Results leave through an output register; when the receiver holds tready low
// the engine waits with the next result and the queue keeps taking requests
// until it is full. Reset empties the table and the queue; no clearing pass
// is needed since only filled rows are read.
`timescale 1ns / 1ps

module record_table_sort_search #(
    parameter int TABLE_DEPTH = rtss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rtss_pkg::IN_DATA_W-1:0]  s_tdata,  // score[31:0], tag[47:32]
    input  logic [rtss_pkg::MODE_W-1:0]     s_tuser,  // mode[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // rank[3:0], row_score[35:4], row_tag[51:36], found[52], zero fill[55:53]
    output logic [rtss_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [rtss_pkg::KIND_W-1:0]     m_tuser,  // kind[1:0]
    output logic                            m_tlast
);
    import rtss_pkg::*;

    localparam int OUT_USED_W = RANK_W + SCORE_W + TAG_W + 1;

    logic      push_valid;
    logic      push_ready;
    cmd_t      push_cmd;
    logic      cmd_valid;
    logic      cmd_ready;
    cmd_t      cmd;
    out_item_t out_item;

    rtss_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    rtss_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_cmd    (cmd)
    );

    rtss_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // Pack the result fields onto the stream.
    assign m_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_item.found, out_item.tag,
                      out_item.score, out_item.rank};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last;

endmodule
